>>> src/bba_pkg.sv
`default_nettype none
package bba_pkg;

  localparam int TOP_ORDER  = 5;
  localparam int PAGE_BYTES = 4096;
  localparam int POOL_UNITS = 1 << TOP_ORDER;
  localparam int MIN_SHIFT  = $clog2(PAGE_BYTES * 4);
  localparam int POOL_SHIFT = MIN_SHIFT + TOP_ORDER;

  localparam int ADDR_W = 64;
  localparam int REQ_W  = 32;
  localparam int IDX_W  = 5;
  localparam int ORD_W  = 3;

  localparam logic [ADDR_W-1:0] MIN_BLOCK_BYTES = ADDR_W'(PAGE_BYTES * 4);
  localparam logic [ADDR_W-1:0] POOL_BYTES = MIN_BLOCK_BYTES << TOP_ORDER;

  // Free marks of all orders packed into one vector, order 0 first.
  localparam int MARK_BITS = 2 * POOL_UNITS - 1;
  localparam int MARK_AW   = TOP_ORDER + 1;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FREED    = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SPLIT,
    S_FREAD,
    S_FCHECK,
    S_MERGE,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic    load;
    logic    init_alloc;
    logic    lvl_inc;
    logic    take;
    logic    split;
    logic    grant;
    logic    ram_rd;
    logic    init_free;
    logic    merge;
    logic    set_mark;
    logic    res_wr;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic too_big;
    logic bad_addr;
    logic lvl_found;
    logic lvl_top;
    logic above_order;
    logic held_bad;
    logic can_merge;
    logic out_free;
  } sts_t;

  // Position of the mark for block pos of order lvl in the packed vector.
  function automatic logic [MARK_AW-1:0] mark_addr(input logic [ORD_W-1:0] lvl,
                                                   input logic [IDX_W-1:0] pos);
    logic [MARK_AW:0] span;
    span = (MARK_AW + 1)'(2 * POOL_UNITS);
    return MARK_AW'(span - (span >> lvl) + (MARK_AW + 1)'(pos));
  endfunction

endpackage
`default_nettype wire

>>> src/bba_if.sv
`default_nettype none
interface bba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [bba_pkg::REQ_W-1:0]  request_bytes;
  logic [bba_pkg::ADDR_W-1:0] free_address;

  modport source(output valid, op, request_bytes, free_address, input ready);
  modport sink(input valid, op, request_bytes, free_address, output ready);
endinterface

interface bba_rsp_if;
  logic                       valid;
  logic                       ready;
  bba_pkg::status_e           status;
  logic [bba_pkg::IDX_W-1:0]  block_index;
  logic [bba_pkg::ORD_W-1:0]  block_order;
  logic [bba_pkg::ADDR_W-1:0] block_address;

  modport source(output valid, status, block_index, block_order, block_address,
                 input ready);
  modport sink(input valid, status, block_index, block_order, block_address,
               output ready);
endinterface
`default_nettype wire

>>> src/bba_ram.sv
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> src/bba_datapath.sv
`default_nettype none
module bba_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bba_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  wire logic                       op_i,
  input  wire logic [bba_pkg::REQ_W-1:0]  request_bytes_i,
  input  wire logic [bba_pkg::ADDR_W-1:0] free_address_i,
  input  wire bba_pkg::cmd_t              cmd_i,
  output bba_pkg::sts_t                   sts_o,
  bba_rsp_if.source                       out_o
);
  import bba_pkg::*;

  logic                    op_q;
  logic [REQ_W-1:0]        req_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [ADDR_W-1:0]       pool_base_q;
  logic [MARK_BITS-1:0]    mark_q, mark_d;
  logic [ORD_W-1:0]        level_q, level_d;
  logic [ORD_W-1:0]        order_q, order_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic [IDX_W-1:0]        index_q, index_d;

  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [IDX_W-1:0]        out_index_q;
  logic [ORD_W-1:0]        out_order_q;
  logic [ADDR_W-1:0]       out_addr_q;

  // Request decode.
  logic [ORD_W-1:0]        req_order;
  logic                    too_big;

  always_comb begin
    req_order = ORD_W'(TOP_ORDER);
    for (int o = TOP_ORDER; o >= 0; o--) begin
      if ({{(ADDR_W-REQ_W){1'b0}}, req_q} <= (MIN_BLOCK_BYTES << o)) begin
        req_order = ORD_W'(o);
      end
    end
    too_big = {{(ADDR_W-REQ_W){1'b0}}, req_q} > POOL_BYTES;
  end

  // Free address decode.
  logic [ADDR_W-1:0]       offset;
  logic                    bad_addr;
  logic [IDX_W-1:0]        off_index;

  assign offset    = addr_q - pool_base_q;
  assign bad_addr  = ((offset >> POOL_SHIFT) != '0) || (offset[MIN_SHIFT-1:0] != '0);
  assign off_index = offset[POOL_SHIFT-1:MIN_SHIFT];

  // Per-order views of the free marks.
  logic [POOL_UNITS-1:0]   lvl_vec [TOP_ORDER+1];
  logic [POOL_UNITS-1:0]   lvl_sel;
  logic [IDX_W-1:0]        first_pos;

  for (genvar g = 0; g <= TOP_ORDER; g++) begin : g_lvl
    localparam int CNT  = POOL_UNITS >> g;
    localparam int BASE = 2 * POOL_UNITS - ((2 * POOL_UNITS) >> g);
    assign lvl_vec[g] = POOL_UNITS'(mark_q[BASE +: CNT]);
  end

  assign lvl_sel = lvl_vec[level_q];

  always_comb begin
    first_pos = '0;
    for (int i = POOL_UNITS - 1; i >= 0; i--) begin
      if (lvl_sel[i]) begin
        first_pos = IDX_W'(i);
      end
    end
  end

  // Held order store.
  logic [ORD_W-1:0]        held;
  logic [IDX_W-1:0]        grant_index;
  logic [IDX_W-1:0]        align_mask;
  logic                    held_marked;

  assign grant_index = pos_q << order_q;

  bba_ram #(
    .WIDTH(ORD_W),
    .DEPTH(POOL_UNITS)
  ) u_held (
    .clk_i  (clk_i),
    .we_i   (cmd_i.grant),
    .waddr_i(grant_index),
    .wdata_i(order_q),
    .re_i   (cmd_i.ram_rd),
    .raddr_i(off_index),
    .rdata_o(held)
  );

  assign align_mask  = (IDX_W'(1) << held) - IDX_W'(1);
  assign held_marked = (held > ORD_W'(TOP_ORDER)) ? 1'b0 :
                       mark_q[mark_addr(held, index_q >> held)];

  // Buddy mark for merging; none above the top order.
  logic                    buddy_free;
  assign buddy_free = (level_q == ORD_W'(TOP_ORDER)) ? 1'b0 :
                      mark_q[mark_addr(level_q, pos_q ^ IDX_W'(1))];

  // Single mark write port.
  logic                    mark_we;
  logic [MARK_AW-1:0]      mark_wa;
  logic                    mark_wv;

  always_comb begin
    mark_we = 1'b0;
    mark_wa = '0;
    mark_wv = 1'b0;
    if (cmd_i.take) begin
      mark_we = 1'b1;
      mark_wa = mark_addr(level_q, first_pos);
    end else if (cmd_i.split) begin
      mark_we = 1'b1;
      mark_wa = mark_addr(level_q - ORD_W'(1), (pos_q << 1) | IDX_W'(1));
      mark_wv = 1'b1;
    end else if (cmd_i.merge) begin
      mark_we = 1'b1;
      mark_wa = mark_addr(level_q, pos_q ^ IDX_W'(1));
    end else if (cmd_i.set_mark) begin
      mark_we = 1'b1;
      mark_wa = mark_addr(level_q, pos_q);
      mark_wv = 1'b1;
    end
  end

  always_comb begin
    mark_d  = mark_q;
    level_d = level_q;
    order_d = order_q;
    pos_d   = pos_q;
    index_d = index_q;
    if (mark_we) begin
      mark_d[mark_wa] = mark_wv;
    end
    if (cmd_i.init_alloc) begin
      level_d = req_order;
      order_d = req_order;
    end
    if (cmd_i.lvl_inc) begin
      level_d = level_q + ORD_W'(1);
    end
    if (cmd_i.take) begin
      pos_d = first_pos;
    end
    if (cmd_i.split) begin
      level_d = level_q - ORD_W'(1);
      pos_d   = pos_q << 1;
    end
    if (cmd_i.grant) begin
      index_d = grant_index;
    end
    if (cmd_i.ram_rd) begin
      index_d = off_index;
    end
    if (cmd_i.init_free) begin
      level_d = held;
      order_d = held;
      pos_d   = index_q >> held;
    end
    if (cmd_i.merge) begin
      level_d = level_q + ORD_W'(1);
      pos_d   = pos_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      mark_q      <= MARK_BITS'(1) << (MARK_BITS - 1);
      level_q     <= '0;
      order_q     <= '0;
      pos_q       <= '0;
      index_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        pool_base_q <= cfg_wdata_i;
      end
      mark_q  <= mark_d;
      level_q <= level_d;
      order_q <= order_d;
      pos_q   <= pos_d;
      index_q <= index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      req_q  <= request_bytes_i;
      addr_q <= free_address_i;
    end
  end

  // Result register.
  logic ok_result;
  assign ok_result = (cmd_i.res_status == ST_GRANTED) || (cmd_i.res_status == ST_FREED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_wr) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_wr) begin
      out_status_q <= cmd_i.res_status;
      out_index_q  <= ok_result ? index_q : '0;
      out_order_q  <= ok_result ? order_q : '0;
      out_addr_q   <= ok_result ? pool_base_q + (ADDR_W'(index_q) << MIN_SHIFT) : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.block_index   = out_index_q;
  assign out_o.block_order   = out_order_q;
  assign out_o.block_address = out_addr_q;

  assign sts_o.is_free     = (op_q == OP_FREE);
  assign sts_o.too_big     = too_big;
  assign sts_o.bad_addr    = bad_addr;
  assign sts_o.lvl_found   = (lvl_sel != '0);
  assign sts_o.lvl_top     = (level_q == ORD_W'(TOP_ORDER));
  assign sts_o.above_order = (level_q != order_q);
  assign sts_o.held_bad    = (held > ORD_W'(TOP_ORDER)) || ((index_q & align_mask) != '0) ||
                             held_marked;
  assign sts_o.can_merge   = buddy_free;
  assign sts_o.out_free    = !out_valid_q || out_o.ready;

  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_wr |-> (!out_valid_q || out_o.ready))
    else $error("result written over a pending item");

  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_we |-> (mark_wa < MARK_AW'(MARK_BITS)))
    else $error("free mark write out of range");

  a_take_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |=> !mark_q[mark_addr(level_q, pos_q)])
    else $error("taken block still marked free");

  a_grant_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grant |-> (level_q == order_q))
    else $error("grant before split reached the request order");

endmodule
`default_nettype wire

>>> src/bba_ctrl.sv
`default_nettype none
module bba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_t      cmd_o
);
  import bba_pkg::*;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_GRANTED;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    status_d         = status_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.res_status = status_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_free) begin
          if (sts_i.bad_addr) begin
            status_d = ST_BAD_FREE;
            state_d  = S_RESULT;
          end else begin
            cmd_o.ram_rd = 1'b1;
            state_d      = S_FREAD;
          end
        end else if (sts_i.too_big) begin
          status_d = ST_NO_SPACE;
          state_d  = S_RESULT;
        end else begin
          cmd_o.init_alloc = 1'b1;
          state_d          = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts_i.lvl_found) begin
          cmd_o.take = 1'b1;
          state_d    = S_SPLIT;
        end else if (sts_i.lvl_top) begin
          status_d = ST_NO_SPACE;
          state_d  = S_RESULT;
        end else begin
          cmd_o.lvl_inc = 1'b1;
        end
      end
      S_SPLIT: begin
        if (sts_i.above_order) begin
          cmd_o.split = 1'b1;
        end else begin
          cmd_o.grant = 1'b1;
          status_d    = ST_GRANTED;
          state_d     = S_RESULT;
        end
      end
      S_FREAD: begin
        state_d = S_FCHECK;
      end
      S_FCHECK: begin
        if (sts_i.held_bad) begin
          status_d = ST_BAD_FREE;
          state_d  = S_RESULT;
        end else begin
          cmd_o.init_free = 1'b1;
          state_d         = S_MERGE;
        end
      end
      S_MERGE: begin
        if (sts_i.can_merge) begin
          cmd_o.merge = 1'b1;
        end else begin
          cmd_o.set_mark = 1'b1;
          status_d       = ST_FREED;
          state_d        = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.res_wr = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_one_mark_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.take, cmd_o.split, cmd_o.merge, cmd_o.set_mark}) <= 1)
    else $error("more than one free mark update in a cycle");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted item not decoded next");

endmodule
`default_nettype wire

>>> src/buddy_block_allocator_top.sv
`default_nettype none
// Buddy allocator: 32 minimum blocks of 4 pages, block orders 0 to 5.
// Grant: decode, search, split, result. No space: ends in decode or search.
// Free: decode, held-order read and check, merge, result; rejected at decode or the check.
// One item is in work at a time; search, split and merge walk one order per cycle.
// The next item is taken in the cycle after the result is written.
// Reset (async, active low): whole pool free, pool base 0, no result pending.
module buddy_block_allocator_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bba_pkg::ADDR_W-1:0] cfg_wdata_i,
  bba_req_if.sink                         in_i,
  bba_rsp_if.source                       out_o
);
  import bba_pkg::*;

  // Command and status between sequencer and datapath.
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // Sequencer: takes one item in idle, then steps through decode,
  // the per-order search/split or the held-order read and merge, and
  // parks in the result state until the output register is free.
  bba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  assign in_i.ready = in_ready;

  // Datapath: free marks in flip-flops, held orders in a small RAM,
  // and the result register that drives the output channel. The result
  // register lets a new item enter while the last result waits.
  bba_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (in_i.op),
    .request_bytes_i(in_i.request_bytes),
    .free_address_i (in_i.free_address),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_o          (out_o)
  );

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps

// Checks the buddy allocator against a behavioral copy of its bookkeeping:
// free marks per order, the order granted at each index and the pool base.
// Every accepted request is predicted at its handshake and the prediction is
// queued; every accepted result is compared field by field with the oldest one.
module testbench;
  import bba_pkg::*;

  // Allow well over the slowest item (sender gap, the work on the item, receiver
  // stall) before calling the run hung.
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEMS_PER_BASE = 400;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  index;
    logic [ORD_W-1:0]  order;
    logic [ADDR_W-1:0] address;
  } outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ADDR_W-1:0] cfg_wdata_i;

  bba_req_if req_if();
  bba_rsp_if rsp_if();

  buddy_block_allocator_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Allocator image kept by the testbench.
  bit               free_map [TOP_ORDER+1][POOL_UNITS];
  logic [ORD_W-1:0] held_order [POOL_UNITS];
  bit               order_known [POOL_UNITS];
  logic [ADDR_W-1:0] base_addr;

  // Indices the testbench believes are handed out; steers the free traffic.
  int live_blocks[$];
  outcome_t pending_outcomes[$];

  bit steady_flow;
  int quiet_cycles;
  int mismatches;
  int items_sent;
  int bases_tried;
  int n_granted, n_no_space, n_freed, n_bad_free;

  function automatic void clear_allocator();
    int lvl, pos;
    for (lvl = 0; lvl <= TOP_ORDER; lvl++)
      for (pos = 0; pos < POOL_UNITS; pos++)
        free_map[lvl][pos] = 1'b0;
    for (pos = 0; pos < POOL_UNITS; pos++) begin
      held_order[pos] = '0;
      order_known[pos] = 1'b0;
    end
    free_map[TOP_ORDER][0] = 1'b1;
    base_addr = '0;
  endfunction

  function automatic logic [ADDR_W-1:0] block_address(input int idx);
    return base_addr + (ADDR_W'(idx) << MIN_SHIFT);
  endfunction

  // Round up to an order, take the lowest free block at or above it and split
  // it down, leaving each upper half free.
  function automatic outcome_t grant_block(input logic [REQ_W-1:0] bytes);
    outcome_t res;
    int want, lvl, pos, p;
    bit hit;
    res.status = ST_NO_SPACE;
    res.index = '0;
    res.order = '0;
    res.address = '0;
    want = 0;
    while (want <= TOP_ORDER && (MIN_BLOCK_BYTES << want) < ADDR_W'(bytes))
      want++;
    if (want > TOP_ORDER)
      return res;
    hit = 1'b0;
    lvl = want;
    pos = 0;
    while (lvl <= TOP_ORDER && !hit) begin
      for (p = 0; p < (1 << (TOP_ORDER - lvl)); p++) begin
        if (!hit && free_map[lvl][p]) begin
          pos = p;
          hit = 1'b1;
        end
      end
      if (!hit)
        lvl++;
    end
    if (!hit)
      return res;
    free_map[lvl][pos] = 1'b0;
    while (lvl > want) begin
      lvl--;
      pos = pos * 2;
      free_map[lvl][pos + 1] = 1'b1;
    end
    pos = pos << want;
    held_order[pos] = ORD_W'(want);
    order_known[pos] = 1'b1;
    res.status = ST_GRANTED;
    res.index = IDX_W'(pos);
    res.order = ORD_W'(want);
    res.address = block_address(pos);
    return res;
  endfunction

  // Reject out-of-pool, misaligned and already-free addresses; otherwise mark
  // the block free and merge it with free buddies upward.
  function automatic outcome_t release_block(input logic [ADDR_W-1:0] addr);
    outcome_t res;
    logic [ADDR_W-1:0] off;
    int idx, ord, lvl, pos;
    res.status = ST_BAD_FREE;
    res.index = '0;
    res.order = '0;
    res.address = '0;
    off = addr - base_addr;
    if (off >= POOL_BYTES || (off & (MIN_BLOCK_BYTES - 1)) != 0)
      return res;
    idx = int'(off >> MIN_SHIFT);
    ord = int'(held_order[idx]);
    if (ord > TOP_ORDER || (idx % (1 << ord)) != 0 || free_map[ord][idx >> ord])
      return res;
    lvl = ord;
    pos = idx >> ord;
    while (lvl < TOP_ORDER && free_map[lvl][pos ^ 1]) begin
      free_map[lvl][pos ^ 1] = 1'b0;
      pos = pos >> 1;
      lvl++;
    end
    free_map[lvl][pos] = 1'b1;
    res.status = ST_FREED;
    res.index = IDX_W'(idx);
    res.order = ORD_W'(ord);
    res.address = block_address(idx);
    return res;
  endfunction

  // Never free an in-pool aligned index that was never granted: its held
  // order is undefined. Knock such an address off alignment instead.
  function automatic logic [ADDR_W-1:0] legal_free_address(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] off;
    off = addr - base_addr;
    if (off < POOL_BYTES && (off & (MIN_BLOCK_BYTES - 1)) == 0 &&
        !order_known[IDX_W'(off >> MIN_SHIFT)])
      return addr ^ ADDR_W'(1);
    return addr;
  endfunction

  function automatic void track_live(input outcome_t res);
    int k;
    if (res.status == ST_GRANTED)
      live_blocks.push_back(int'(res.index));
    if (res.status == ST_FREED) begin
      for (k = 0; k < live_blocks.size(); k++) begin
        if (live_blocks[k] == int'(res.index)) begin
          live_blocks.delete(k);
          break;
        end
      end
    end
  endfunction

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Hold valid through the handshake; keep it high into the next item when
  // that item has no gap, so valid is never dropped and raised in one step.
  task automatic send_item(input op_e op, input logic [REQ_W-1:0] bytes,
                           input logic [ADDR_W-1:0] addr);
    int gap;
    outcome_t want;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.request_bytes <= bytes;
    req_if.free_address <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (op == OP_ALLOC)
      want = grant_block(bytes);
    else
      want = release_block(addr);
    track_live(want);
    pending_outcomes.push_back(want);
    items_sent++;
  endtask

  task automatic alloc_bytes(input logic [REQ_W-1:0] bytes);
    send_item(OP_ALLOC, bytes, {$urandom, $urandom});
  endtask

  task automatic free_at(input logic [ADDR_W-1:0] addr);
    send_item(OP_FREE, REQ_W'($urandom), legal_free_address(addr));
  endtask

  task automatic free_index(input int idx);
    free_at(block_address(idx));
  endtask

  // Drop valid and wait for the block to drain before touching the register.
  task automatic settle_block();
    req_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_pool_base(input logic [ADDR_W-1:0] value);
    settle_block();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    base_addr = value;
    bases_tried++;
  endtask

  task automatic check_result();
    outcome_t want;
    if (pending_outcomes.size() == 0) begin
      report_error($sformatf("unexpected result, status %0d index %0d",
                             rsp_if.status, rsp_if.block_index));
      return;
    end
    want = pending_outcomes.pop_front();
    case (want.status)
      ST_GRANTED:  n_granted++;
      ST_NO_SPACE: n_no_space++;
      ST_FREED:    n_freed++;
      default:     n_bad_free++;
    endcase
    if (rsp_if.status !== want.status)
      report_error($sformatf("status got %0d want %0d", rsp_if.status, want.status));
    if (rsp_if.block_index !== want.index)
      report_error($sformatf("block_index got %0d want %0d", rsp_if.block_index, want.index));
    if (rsp_if.block_order !== want.order)
      report_error($sformatf("block_order got %0d want %0d", rsp_if.block_order, want.order));
    if (rsp_if.block_address !== want.address)
      report_error($sformatf("block_address got %h want %h",
                             rsp_if.block_address, want.address));
  endtask

  // Result side: draw a stall per item, then take the next result.
  initial begin : result_monitor
    int gap;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      check_result();
    end
  end

  // Count cycles with no handshake on either side; end a hung run.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] timeout: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_outcomes.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [REQ_W-1:0] draw_request();
    int pick, ord, alt;
    logic [REQ_W-1:0] lo, hi;
    pick = $urandom_range(0, 99);
    ord = $urandom_range(0, TOP_ORDER);
    alt = $urandom_range(0, TOP_ORDER);
    if (pick < 4)
      return '0;
    if (pick < 9)
      return REQ_W'($urandom);
    if (pick < 14)
      return REQ_W'(MIN_BLOCK_BYTES << ord) + REQ_W'($urandom_range(0, 1));
    if (pick < 16)
      return REQ_W'(POOL_BYTES) + REQ_W'($urandom_range(1, 1000));
    // Skew toward small orders so the pool fragments and merges often.
    if (alt < ord)
      ord = alt;
    hi = REQ_W'(MIN_BLOCK_BYTES << ord);
    lo = (ord == 0) ? REQ_W'(1) : (hi >> 1) + REQ_W'(1);
    return REQ_W'($urandom_range(hi, lo));
  endfunction

  task automatic free_random();
    int pick, k;
    int known[$];
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    for (k = 0; k < POOL_UNITS; k++)
      if (order_known[k])
        known.push_back(k);
    if (pick < 82 && live_blocks.size() > 0) begin
      addr = block_address(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
    end else if (pick < 86 && known.size() > 0) begin
      // Double free, or free of a stale index.
      addr = block_address(known[$urandom_range(0, known.size() - 1)]);
    end else begin
      case ($urandom_range(0, 3))
        0:       addr = {$urandom, $urandom};
        1:       addr = base_addr + POOL_BYTES +
                        (ADDR_W'($urandom_range(0, 40)) << MIN_SHIFT);
        2:       addr = base_addr - (ADDR_W'($urandom_range(1, 40)) << MIN_SHIFT);
        default: addr = block_address($urandom_range(0, POOL_UNITS - 1)) +
                        ADDR_W'($urandom_range(1, int'(MIN_BLOCK_BYTES) - 1));
      endcase
    end
    free_at(addr);
  endtask

  task automatic run_random(input int n_items);
    int i, alloc_pct;
    for (i = 0; i < n_items; i++) begin
      // Switch between stretches with random gaps and full-rate stretches.
      if (i % 50 == 0)
        steady_flow = ($urandom_range(0, 3) == 0);
      if (live_blocks.size() == 0)
        alloc_pct = 95;
      else if (live_blocks.size() > 10)
        alloc_pct = 35;
      else
        alloc_pct = 55;
      if ($urandom_range(0, 99) < alloc_pct)
        alloc_bytes(draw_request());
      else
        free_random();
    end
    steady_flow = 1'b0;
  endtask

  // Field extremes, every result kind, splits and merges, at the reset base.
  task automatic test_directed();
    free_at(POOL_BYTES);                        // just past the pool
    free_at({ADDR_W{1'b1}});                    // far out and misaligned
    alloc_bytes('0);                            // zero request, full split
    alloc_bytes(REQ_W'(1));
    alloc_bytes(REQ_W'(MIN_BLOCK_BYTES));
    alloc_bytes(REQ_W'(MIN_BLOCK_BYTES) + 1);   // rounds up to order 1
    alloc_bytes(REQ_W'(POOL_BYTES) + 1);        // too large
    alloc_bytes({REQ_W{1'b1}});
    alloc_bytes(REQ_W'(POOL_BYTES));            // no whole-pool block left
    free_at(block_address(2) + 4);              // inside a block
    free_index(1);
    free_index(1);                              // double free
    free_index(2);
    free_index(0);
    free_index(4);                              // merges back to the whole pool
    alloc_bytes(REQ_W'(POOL_BYTES));
    alloc_bytes('0);                            // pool exhausted
    free_index(0);
    alloc_bytes(REQ_W'(MIN_BLOCK_BYTES << (TOP_ORDER - 1)));
    alloc_bytes(REQ_W'(MIN_BLOCK_BYTES << (TOP_ORDER - 1)));
    free_index(POOL_UNITS / 2);
    free_index(0);
  endtask

  // Random traffic under several pool bases, the extremes among them.
  task automatic test_pool_bases();
    logic [ADDR_W-1:0] aligned_mask;
    aligned_mask = ~(POOL_BYTES - 1);
    write_pool_base({ADDR_W{1'b1}});
    run_random(ITEMS_PER_BASE);
    write_pool_base({$urandom, $urandom} & aligned_mask);
    run_random(ITEMS_PER_BASE);
    write_pool_base('0);
    run_random(ITEMS_PER_BASE);
    write_pool_base({$urandom, $urandom});
    run_random(ITEMS_PER_BASE);
    write_pool_base(aligned_mask);              // top of the address space
    run_random(ITEMS_PER_BASE);
  endtask

  // Return every live block, then free indices that are no longer granted:
  // the first passes the checks and is carried out, the repeat is rejected.
  task automatic test_stale_free();
    int guard, idx, k;
    guard = 0;
    while (live_blocks.size() > 0 && guard < 2 * POOL_UNITS) begin
      idx = live_blocks.pop_front();
      free_index(idx);
      guard++;
    end
    for (k = 1; k < POOL_UNITS; k++) begin
      if (order_known[k] && guard < 3 * POOL_UNITS) begin
        free_index(k);
        free_index(k);
        guard += POOL_UNITS;
      end
    end
    alloc_bytes('0);
    alloc_bytes(REQ_W'(POOL_BYTES));
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    req_if.valid <= 1'b0;
    req_if.op <= OP_ALLOC;
    req_if.request_bytes <= '0;
    req_if.free_address <= '0;
    steady_flow = 1'b0;
    clear_allocator();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_pool_bases();
    test_stale_free();

    settle_block();
    $display("Ran %0d items over %0d written pool bases plus the reset base.",
             items_sent, bases_tried);
    $display("Results: %0d granted, %0d no space, %0d freed, %0d bad frees; %0d mismatches.",
             n_granted, n_no_space, n_freed, n_bad_free, mismatches);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
